// ===== hdl/bfs_fsf_pkg.sv =====
// Shared types and constants for the breadth-first first-step finder.
// Used by bfs_fsf_store, bfs_fsf_seq and bfs_first_step_finder_core.
package bfs_fsf_pkg;

   // Default sizes
   localparam int ROOMS_DEF     = 1024;
   localparam int MAX_EXITS_DEF = 16;
   localparam int AREA_BITS_DEF = 8;

   // Command codes
   localparam logic [1:0] CMD_WRITE_EXIT = 2'd0;
   localparam logic [1:0] CMD_WRITE_AREA = 2'd1;
   localparam logic [1:0] CMD_FIND_STEP  = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_FOUND  = 2'd0;
   localparam logic [1:0] STATUS_THERE  = 2'd1;
   localparam logic [1:0] STATUS_NOPATH = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [9:0]  room;
      logic [3:0]  exit_slot;
      logic        exit_present;
      logic [3:0]  exit_direction;
      logic [9:0]  neighbor;
      logic [7:0]  area_id;
      logic [9:0]  target_room;
      logic [15:0] step_limit;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] first_direction;
   } rsp_word_type;

   // Write strobes from the sequencer to the tables
   typedef struct packed {
      logic exit_we;
      logic area_we;
      logic mark_we;
      logic mark_wdata;
      logic queue_we;
   } mem_ctl_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_AREA_SRC,
      ST_AREA_TGT,
      ST_AREA_CMP,
      ST_MARK_SRC,
      ST_EXIT_RD,
      ST_EXIT_CHK,
      ST_MARK_CHK,
      ST_DEQ_RD,
      ST_DEQ_CHK,
      ST_WIPE_SRC,
      ST_WIPE_RD,
      ST_WIPE_WR,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/bfs_first_step_finder_core.sv =====
// Top level of the breadth-first first-step finder: sequencer, tables and
// result register. Depends on bfs_fsf_pkg, bfs_fsf_seq, bfs_fsf_store.
//
//   channel  ports                         carries
//   request  req_valid/req_stall/req_word  table writes and queries
//   result   rsp_valid/rsp_stall/rsp_word  one word per query
//
// A query is decided on room numbers, or on the areas when they differ. A
// search scans each exit slot of the source and of each expanded room,
// dequeues rooms and clears the visit marks of the source and each queued
// room: one table access a step. After reset a clearing pass over all
// ROOMS*MAX_EXITS exit entries runs with req_stall high. A waiting result
// holds in its register; writes are still taken.
module bfs_first_step_finder_core import bfs_fsf_pkg::*; #(
   parameter int ROOMS     = ROOMS_DEF,
   parameter int MAX_EXITS = MAX_EXITS_DEF,
   parameter int AREA_BITS = AREA_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int RW  = $clog2(ROOMS);
   localparam int EAW = $clog2(ROOMS * MAX_EXITS);
   localparam int EW  = RW + 5;
   localparam int QW  = RW + 4;

   mem_ctl_type          ctl;
   logic [EAW-1:0]       exit_addr;
   logic [EW-1:0]        exit_wdata, exit_rdata;
   logic [RW-1:0]        area_addr, mark_addr, queue_addr;
   logic [AREA_BITS-1:0] area_wdata, area_rdata;
   logic                 mark_rdata;
   logic [QW-1:0]        queue_wdata, queue_rdata;
   logic                 busy, done, out_free;
   rsp_word_type         done_word;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff;

   bfs_fsf_seq #(
      .ROOMS(ROOMS), .MAX_EXITS(MAX_EXITS), .AREA_BITS(AREA_BITS)
   ) u_seq (
      .clock, .reset, .req_valid, .req_word, .busy, .out_free, .done,
      .done_word, .ctl, .exit_addr, .exit_wdata, .exit_rdata,
      .area_addr, .area_wdata, .area_rdata, .mark_addr, .mark_rdata,
      .queue_addr, .queue_wdata, .queue_rdata
   );

   bfs_fsf_store #(
      .ROOMS(ROOMS), .MAX_EXITS(MAX_EXITS), .AREA_BITS(AREA_BITS)
   ) u_store (
      .clock, .ctl, .exit_addr, .exit_wdata, .exit_rdata,
      .area_addr, .area_wdata, .area_rdata, .mark_addr, .mark_rdata,
      .queue_addr, .queue_wdata, .queue_rdata
   );

   // Result register
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_word_ff <= done_word;
      end
   end

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== hdl/bfs_fsf_store.sv =====
// Table memories: exit table, area table, visit marks and search queue.
// Single port each, registered read. Depends on bfs_fsf_pkg.
module bfs_fsf_store import bfs_fsf_pkg::*; #(
   parameter int ROOMS     = ROOMS_DEF,
   parameter int MAX_EXITS = MAX_EXITS_DEF,
   parameter int AREA_BITS = AREA_BITS_DEF,
   localparam int RW         = $clog2(ROOMS),
   localparam int EXIT_DEPTH = ROOMS * MAX_EXITS,
   localparam int EAW        = $clog2(EXIT_DEPTH),
   localparam int EW         = RW + 5,
   localparam int QW         = RW + 4
) (
   input  logic                 clock,
   input  mem_ctl_type          ctl,
   input  logic [EAW-1:0]       exit_addr,
   input  logic [EW-1:0]        exit_wdata,
   output logic [EW-1:0]        exit_rdata,
   input  logic [RW-1:0]        area_addr,
   input  logic [AREA_BITS-1:0] area_wdata,
   output logic [AREA_BITS-1:0] area_rdata,
   input  logic [RW-1:0]        mark_addr,
   output logic                 mark_rdata,
   input  logic [RW-1:0]        queue_addr,
   input  logic [QW-1:0]        queue_wdata,
   output logic [QW-1:0]        queue_rdata
);

   logic [EW-1:0]        exit_mem  [EXIT_DEPTH];
   logic [AREA_BITS-1:0] area_mem  [ROOMS];
   logic                 mark_mem  [ROOMS];
   logic [QW-1:0]        queue_mem [ROOMS];

   logic [EW-1:0]        exit_rdata_ff;
   logic [AREA_BITS-1:0] area_rdata_ff;
   logic                 mark_rdata_ff;
   logic [QW-1:0]        queue_rdata_ff;

   // Exit table: {present, direction, neighbour}
   always_ff @(posedge clock) begin
      if (ctl.exit_we) begin
         exit_mem[exit_addr] <= exit_wdata;
      end
      exit_rdata_ff <= exit_mem[exit_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.area_we) begin
         area_mem[area_addr] <= area_wdata;
      end
      area_rdata_ff <= area_mem[area_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.mark_we) begin
         mark_mem[mark_addr] <= ctl.mark_wdata;
      end
      mark_rdata_ff <= mark_mem[mark_addr];
   end

   // Search queue: {room, first direction}
   always_ff @(posedge clock) begin
      if (ctl.queue_we) begin
         queue_mem[queue_addr] <= queue_wdata;
      end
      queue_rdata_ff <= queue_mem[queue_addr];
   end

   assign exit_rdata  = exit_rdata_ff;
   assign area_rdata  = area_rdata_ff;
   assign mark_rdata  = mark_rdata_ff;
   assign queue_rdata = queue_rdata_ff;

endmodule

// ===== hdl/bfs_fsf_seq.sv =====
// Sequencer for table writes and the breadth-first search, one memory
// access per step. Depends on bfs_fsf_pkg; drives bfs_fsf_store.
module bfs_fsf_seq import bfs_fsf_pkg::*; #(
   parameter int ROOMS     = ROOMS_DEF,
   parameter int MAX_EXITS = MAX_EXITS_DEF,
   parameter int AREA_BITS = AREA_BITS_DEF,
   localparam int RW         = $clog2(ROOMS),
   localparam int EXIT_DEPTH = ROOMS * MAX_EXITS,
   localparam int EAW        = $clog2(EXIT_DEPTH),
   localparam int SW         = (MAX_EXITS > 1) ? $clog2(MAX_EXITS) : 1,
   localparam int EW         = RW + 5,
   localparam int QW         = RW + 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  req_word_type         req_word,
   output logic                 busy,
   input  logic                 out_free,
   output logic                 done,
   output rsp_word_type         done_word,
   output mem_ctl_type          ctl,
   output logic [EAW-1:0]       exit_addr,
   output logic [EW-1:0]        exit_wdata,
   input  logic [EW-1:0]        exit_rdata,
   output logic [RW-1:0]        area_addr,
   output logic [AREA_BITS-1:0] area_wdata,
   input  logic [AREA_BITS-1:0] area_rdata,
   output logic [RW-1:0]        mark_addr,
   input  logic                 mark_rdata,
   output logic [RW-1:0]        queue_addr,
   output logic [QW-1:0]        queue_wdata,
   input  logic [QW-1:0]        queue_rdata
);

   state_type            state_ff, state_in;
   logic [EAW-1:0]       sweep_ff, sweep_in;
   logic [RW-1:0]        src_ff, src_in;
   logic [RW-1:0]        tgt_ff, tgt_in;
   logic [15:0]          limit_ff, limit_in;
   logic [AREA_BITS-1:0] area_src_ff, area_src_in;
   logic [RW-1:0]        cur_ff, cur_in;
   logic                 own_ff, own_in;
   logic [3:0]           inh_ff, inh_in;
   logic [SW-1:0]        slot_ff, slot_in;
   logic [RW-1:0]        nb_ff, nb_in;
   logic [3:0]           edir_ff, edir_in;
   logic [RW:0]          head_ff, head_in;
   logic [RW:0]          tail_ff, tail_in;
   logic [16:0]          count_ff, count_in;
   logic [1:0]           status_ff, status_in;
   logic [3:0]           fdir_ff, fdir_in;

   logic           room_ok, tgt_ok, slot_ok, nb_ok, last_slot;
   logic [EAW-1:0] wr_exit_addr, rd_exit_addr;
   logic [RW-1:0]  q_room;
   logic [3:0]     q_dir;
   logic [16:0]    count_next;

   assign room_ok = 32'(req_word.room) < 32'(ROOMS);
   assign tgt_ok  = 32'(req_word.target_room) < 32'(ROOMS);
   assign nb_ok   = 32'(req_word.neighbor) < 32'(ROOMS);
   assign slot_ok = 32'(req_word.exit_slot) < 32'(MAX_EXITS);
   assign wr_exit_addr = EAW'(RW'(req_word.room)) * EAW'(MAX_EXITS)
                       + EAW'(req_word.exit_slot);
   assign rd_exit_addr = EAW'(cur_ff) * EAW'(MAX_EXITS) + EAW'(slot_ff);
   assign last_slot  = slot_ff == SW'(MAX_EXITS - 1);
   assign q_room     = queue_rdata[QW-1:4];
   assign q_dir      = queue_rdata[3:0];
   assign count_next = count_ff + 17'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         sweep_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      tgt_ff      <= tgt_in;
      limit_ff    <= limit_in;
      area_src_ff <= area_src_in;
      cur_ff      <= cur_in;
      own_ff      <= own_in;
      inh_ff      <= inh_in;
      slot_ff     <= slot_in;
      nb_ff       <= nb_in;
      edir_ff     <= edir_in;
      status_ff   <= status_in;
      fdir_ff     <= fdir_in;
   end

   // Next state, table strobes and addresses
   always_comb begin
      state_in    = state_ff;
      sweep_in    = sweep_ff;
      src_in      = src_ff;
      tgt_in      = tgt_ff;
      limit_in    = limit_ff;
      area_src_in = area_src_ff;
      cur_in      = cur_ff;
      own_in      = own_ff;
      inh_in      = inh_ff;
      slot_in     = slot_ff;
      nb_in       = nb_ff;
      edir_in     = edir_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      fdir_in     = fdir_ff;
      ctl         = '0;
      exit_addr   = rd_exit_addr;
      exit_wdata  = '0;
      area_addr   = src_ff;
      area_wdata  = AREA_BITS'(req_word.area_id);
      mark_addr   = nb_ff;
      queue_addr  = head_ff[RW-1:0];
      queue_wdata = {nb_ff, own_ff ? edir_ff : inh_ff};
      done        = 1'b0;

      case (state_ff)
         // Clear exits and marks after reset
         ST_SWEEP: begin
            ctl.exit_we = 1'b1;
            ctl.mark_we = 1'b1;
            exit_addr   = sweep_ff;
            mark_addr   = sweep_ff[RW-1:0];
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_ff == EAW'(EXIT_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_word.command)
                  CMD_WRITE_EXIT: begin
                     if (room_ok && slot_ok) begin
                        ctl.exit_we = 1'b1;
                        exit_addr   = wr_exit_addr;
                        if (req_word.exit_present && nb_ok) begin
                           exit_wdata = {1'b1, req_word.exit_direction,
                                         RW'(req_word.neighbor)};
                        end
                     end
                  end
                  CMD_WRITE_AREA: begin
                     if (room_ok) begin
                        ctl.area_we = 1'b1;
                        area_addr   = RW'(req_word.room);
                     end
                  end
                  CMD_FIND_STEP: begin
                     src_in    = RW'(req_word.room);
                     tgt_in    = RW'(req_word.target_room);
                     limit_in  = req_word.step_limit;
                     status_in = STATUS_NOPATH;
                     fdir_in   = 4'd0;
                     if (!room_ok || !tgt_ok) begin
                        state_in = ST_DONE;
                     end else if (req_word.room == req_word.target_room) begin
                        status_in = STATUS_THERE;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_AREA_SRC;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_AREA_SRC: begin
            area_addr = src_ff;
            state_in  = ST_AREA_TGT;
         end
         ST_AREA_TGT: begin
            area_addr   = tgt_ff;
            area_src_in = area_rdata;
            state_in    = ST_AREA_CMP;
         end
         ST_AREA_CMP: begin
            state_in = (area_rdata == area_src_ff) ? ST_MARK_SRC : ST_DONE;
         end
         // Mark the source and expand it with each exit's own direction
         ST_MARK_SRC: begin
            ctl.mark_we    = 1'b1;
            ctl.mark_wdata = 1'b1;
            mark_addr      = src_ff;
            cur_in         = src_ff;
            own_in         = 1'b1;
            inh_in         = 4'd0;
            slot_in        = '0;
            head_in        = '0;
            tail_in        = '0;
            count_in       = '0;
            state_in       = ST_EXIT_RD;
         end
         ST_EXIT_RD: begin
            exit_addr = rd_exit_addr;
            state_in  = ST_EXIT_CHK;
         end
         ST_EXIT_CHK: begin
            if (exit_rdata[EW-1]) begin
               nb_in     = exit_rdata[RW-1:0];
               edir_in   = exit_rdata[RW+3:RW];
               mark_addr = exit_rdata[RW-1:0];
               state_in  = ST_MARK_CHK;
            end else if (last_slot) begin
               state_in = ST_DEQ_RD;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_EXIT_RD;
            end
         end
         // Unvisited neighbour: mark and enqueue
         ST_MARK_CHK: begin
            if (!mark_rdata) begin
               ctl.mark_we    = 1'b1;
               ctl.mark_wdata = 1'b1;
               mark_addr      = nb_ff;
               if (tail_ff < (RW+1)'(ROOMS)) begin
                  ctl.queue_we = 1'b1;
                  queue_addr   = tail_ff[RW-1:0];
                  tail_in      = tail_ff + 1'b1;
               end
            end
            if (last_slot) begin
               state_in = ST_DEQ_RD;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_EXIT_RD;
            end
         end
         ST_DEQ_RD: begin
            if (head_ff < tail_ff) begin
               queue_addr = head_ff[RW-1:0];
               state_in   = ST_DEQ_CHK;
            end else begin
               state_in = ST_WIPE_SRC;
            end
         end
         ST_DEQ_CHK: begin
            count_in = count_next;
            if (count_next > {1'b0, limit_ff}) begin
               state_in = ST_WIPE_SRC;
            end else if (q_room == tgt_ff) begin
               status_in = STATUS_FOUND;
               fdir_in   = q_dir;
               state_in  = ST_WIPE_SRC;
            end else begin
               cur_in   = q_room;
               inh_in   = q_dir;
               own_in   = 1'b0;
               slot_in  = '0;
               head_in  = head_ff + 1'b1;
               state_in = ST_EXIT_RD;
            end
         end
         // Clear marks: the source, then every queued room
         ST_WIPE_SRC: begin
            ctl.mark_we = 1'b1;
            mark_addr   = src_ff;
            head_in     = '0;
            state_in    = ST_WIPE_RD;
         end
         ST_WIPE_RD: begin
            if (head_ff < tail_ff) begin
               queue_addr = head_ff[RW-1:0];
               state_in   = ST_WIPE_WR;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WIPE_WR: begin
            ctl.mark_we = 1'b1;
            mark_addr   = q_room;
            head_in     = head_ff + 1'b1;
            state_in    = ST_WIPE_RD;
         end
         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy                      = state_ff != ST_IDLE;
   assign done_word.status          = status_ff;
   assign done_word.first_direction = fdir_ff;

   // Queue read pointer never passes the write pointer
   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("queue head passed tail");

   // Queue never holds more than one entry per room
   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= (RW+1)'(ROOMS))
      else $error("queue tail beyond room count");

   // Search continues only while the dequeue count is within the limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEQ_RD) |-> (count_ff <= {1'b0, limit_ff}))
      else $error("dequeue count over limit during search");

endmodule
